/* rtl/bpc_pkg.sv */
// Shared widths, constants, types and helpers for the barometric compensation pipeline.
package bpc_pkg;

  localparam int D_W    = 24;
  localparam int CAL_W  = 16;
  localparam int IDX_W  = 3;
  localparam int DT_W   = D_W + 1;
  localparam int MUL_W  = DT_W + CAL_W + 1;
  localparam int DSQ_W  = 2 * DT_W;
  localparam int TEMP_W = 19;
  localparam int T2_W   = 17;
  localparam int OFF_W  = 40;
  localparam int SENS_W = 40;
  localparam int SQ_W   = 34;
  localparam int CORR_W = 38;
  localparam int HALF_W = D_W / 2;
  localparam int PP_W   = SENS_W + HALF_W + 1;
  localparam int PROD_W = 64;
  localparam int ACC_W  = 48;
  localparam int TOUT_W = 15;
  localparam int POUT_W = 17;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_COLD = -1500;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRES_MIN  = 1000;
  localparam int PRES_MAX  = 120000;

  localparam logic [IDX_W-1:0] IDX_C1 = 3'd0;
  localparam logic [IDX_W-1:0] IDX_C2 = 3'd1;
  localparam logic [IDX_W-1:0] IDX_C3 = 3'd2;
  localparam logic [IDX_W-1:0] IDX_C4 = 3'd3;
  localparam logic [IDX_W-1:0] IDX_C5 = 3'd4;
  localparam logic [IDX_W-1:0] IDX_C6 = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  offs;
    logic signed [SENS_W-1:0] sens;
    logic [T2_W-1:0]          t2;
    logic [D_W-1:0]           d1;
  } stage_t;

  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] v,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

/* rtl/baro_temp_pressure_compensation_top.sv */
// Top level of the barometric temperature and pressure compensation pipeline.
//
// Load the six calibration words through the configuration channel: cfg_index
// selects the word (0..5, higher indexes are dropped), cfg_data carries it, and a
// transfer happens on an edge with cfg_valid and cfg_ready high. cfg_ready is
// high whenever reset is low. Write calibration only while the pipeline is empty.
// Start a conversion by raising start with raw_pressure and raw_temperature;
// the pair is taken on any edge where start is high and busy is low. busy is
// high only during reset, so a new pair can enter on every clock cycle.
// Each pair passes through ten register stages; done pulses for one cycle with
// temperature_centi and pressure_centi, and the result is taken at the edge that
// ends that cycle. Sustained rate is one result per cycle, set by the ten-stage
// datapath with split 40x12 pressure products. The receiver cannot stall the
// pipeline. Reset clears the calibration words to zero and drops every
// conversion in flight.
module baro_temp_pressure_compensation_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bpc_pkg::D_W-1:0]           raw_pressure,
  input  logic [bpc_pkg::D_W-1:0]           raw_temperature,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]         cfg_data,
  output logic                              done,
  output logic signed [bpc_pkg::TOUT_W-1:0] temperature_centi,
  output logic [bpc_pkg::POUT_W-1:0]        pressure_centi
);
  import bpc_pkg::*;

  cal_t   cal;
  stage_t fo_stage, so_stage;
  logic   fo_valid, so_valid;

  assign busy      = rst;
  assign cfg_ready = ~rst;

  bpc_cal_regs u_cal_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cal      (cal)
  );

  bpc_first_order u_first_order (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (start & ~busy),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .cal             (cal),
    .out_valid       (fo_valid),
    .stg_out         (fo_stage)
  );

  bpc_second_order u_second_order (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fo_valid),
    .stg_in    (fo_stage),
    .out_valid (so_valid),
    .stg_out   (so_stage)
  );

  bpc_pressure u_pressure (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (so_valid),
    .stg_in            (so_stage),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##10 done)
    else $error("transfer did not produce a result after ten cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 10))
    else $error("result without a matching input transfer");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (temperature_centi >= TOUT_W'(TEMP_MIN) &&
              temperature_centi <= TOUT_W'(TEMP_MAX)))
    else $error("temperature outside saturation bounds");

  a_pres_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pressure_centi >= POUT_W'(PRES_MIN) &&
              pressure_centi <= POUT_W'(PRES_MAX)))
    else $error("pressure outside saturation bounds");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

endmodule

/* rtl/bpc_cal_regs.sv */
// Calibration word registers written through the configuration channel.
module bpc_cal_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [bpc_pkg::IDX_W-1:0] wr_index,
  input  logic [bpc_pkg::CAL_W-1:0] wr_data,
  output bpc_pkg::cal_t             cal
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        IDX_C1: cal.c1 <= wr_data;
        IDX_C2: cal.c2 <= wr_data;
        IDX_C3: cal.c3 <= wr_data;
        IDX_C4: cal.c4 <= wr_data;
        IDX_C5: cal.c5 <= wr_data;
        IDX_C6: cal.c6 <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/bpc_first_order.sv */
// First-order terms: dT, calibration products, TEMP, OFF, SENS and T2.
module bpc_first_order (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [bpc_pkg::D_W-1:0] raw_pressure,
  input  logic [bpc_pkg::D_W-1:0] raw_temperature,
  input  bpc_pkg::cal_t           cal,
  output logic                    out_valid,
  output bpc_pkg::stage_t         stg_out
);
  import bpc_pkg::*;

  logic                    v1, v2, v3;
  logic signed [DT_W-1:0]  dt;
  logic [D_W-1:0]          d1_s1, d1_s2;
  logic signed [MUL_W-1:0] p6, p4, p3;
  logic signed [DSQ_W-1:0] dsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dt    <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'b0});
    d1_s1 <= raw_pressure;

    p6    <= dt * $signed({1'b0, cal.c6});
    p4    <= dt * $signed({1'b0, cal.c4});
    p3    <= dt * $signed({1'b0, cal.c3});
    dsq   <= dt * dt;
    d1_s2 <= d1_s1;

    stg_out.temp <= TEMP_W'(sdiv_pow2(64'(p6), 23) + 64'(TEMP_REF));
    stg_out.offs <= OFF_W'($signed({1'b0, cal.c2, 16'b0}) + sdiv_pow2(64'(p4), 7));
    stg_out.sens <= SENS_W'($signed({1'b0, cal.c1, 15'b0}) + sdiv_pow2(64'(p3), 8));
    stg_out.t2   <= dsq[T2_W+30:31];
    stg_out.d1   <= d1_s2;
  end

  assign out_valid = v3;

endmodule

/* rtl/bpc_second_order.sv */
// Second-order low-temperature correction of TEMP, OFF and SENS.
module bpc_second_order (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  bpc_pkg::stage_t stg_in,
  output logic            out_valid,
  output bpc_pkg::stage_t stg_out
);
  import bpc_pkg::*;

  logic                     v4, v5, v6;
  logic signed [TEMP_W-1:0] below, cold;
  logic signed [2*TEMP_W-1:0] below_sq, cold_sq;
  stage_t                   st4, st5, st5_next;
  logic [SQ_W-1:0]          sq, sq2;
  logic                     warm_low, cold_low;
  logic [CORR_W-1:0]        sq5, sq7, sq11;
  logic [CORR_W-1:0]        offs2, sens2, offs2_next, sens2_next;

  assign below    = stg_in.temp - TEMP_W'(TEMP_REF);
  assign cold     = stg_in.temp - TEMP_W'(TEMP_COLD);
  assign below_sq = below * below;
  assign cold_sq  = cold * cold;

  always_comb begin
    sq5  = (CORR_W'(sq) << 2) + CORR_W'(sq);
    sq7  = (CORR_W'(sq2) << 3) - CORR_W'(sq2);
    sq11 = (CORR_W'(sq2) << 3) + (CORR_W'(sq2) << 1) + CORR_W'(sq2);
    st5_next    = st4;
    st5_next.t2 = '0;
    offs2_next  = '0;
    sens2_next  = '0;
    if (warm_low) begin
      st5_next.t2 = st4.t2;
      offs2_next  = sq5 >> 1;
      sens2_next  = sq5 >> 2;
      if (cold_low) begin
        offs2_next = offs2_next + sq7;
        sens2_next = sens2_next + (sq11 >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    st4      <= stg_in;
    sq       <= below_sq[SQ_W-1:0];
    sq2      <= cold_sq[SQ_W-1:0];
    warm_low <= stg_in.temp < TEMP_W'(TEMP_REF);
    cold_low <= stg_in.temp < TEMP_W'(TEMP_COLD);

    st5   <= st5_next;
    offs2 <= offs2_next;
    sens2 <= sens2_next;

    stg_out.temp <= st5.temp - $signed({2'b0, st5.t2});
    stg_out.offs <= st5.offs - $signed({2'b0, offs2});
    stg_out.sens <= st5.sens - $signed({2'b0, sens2});
    stg_out.t2   <= st5.t2;
    stg_out.d1   <= st5.d1;
  end

  assign out_valid = v6;

endmodule

/* rtl/bpc_pressure.sv */
// Pressure product, scaling, offset removal and output saturation.
module bpc_pressure (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  bpc_pkg::stage_t                    stg_in,
  output logic                               done,
  output logic signed [bpc_pkg::TOUT_W-1:0]  temperature_centi,
  output logic [bpc_pkg::POUT_W-1:0]         pressure_centi
);
  import bpc_pkg::*;

  logic                     v7, v8, v9, v10;
  logic signed [PP_W-1:0]   pp_lo, pp_hi;
  logic signed [TOUT_W-1:0] tq_next, tq7, tq8, tq9;
  logic signed [OFF_W-1:0]  offs7, offs8;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [63:0]       pres;
  logic [POUT_W-1:0]        pq_next;

  always_comb begin
    priority if (stg_in.temp < TEMP_MIN) begin
      tq_next = TOUT_W'(TEMP_MIN);
    end else if (stg_in.temp > TEMP_MAX) begin
      tq_next = TOUT_W'(TEMP_MAX);
    end else begin
      tq_next = stg_in.temp[TOUT_W-1:0];
    end
  end

  always_comb begin
    pres = sdiv_pow2(64'(acc), 15);
    priority if (pres < 64'(PRES_MIN)) begin
      pq_next = POUT_W'(PRES_MIN);
    end else if (pres > 64'(PRES_MAX)) begin
      pq_next = POUT_W'(PRES_MAX);
    end else begin
      pq_next = pres[POUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      v7  <= in_valid;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo <= stg_in.sens * $signed({1'b0, stg_in.d1[HALF_W-1:0]});
    pp_hi <= stg_in.sens * $signed({1'b0, stg_in.d1[D_W-1:HALF_W]});
    tq7   <= tq_next;
    offs7 <= stg_in.offs;

    prod  <= (PROD_W'(pp_hi) <<< HALF_W) + PROD_W'(pp_lo);
    tq8   <= tq7;
    offs8 <= offs7;

    acc   <= ACC_W'(sdiv_pow2(prod, 21)) - ACC_W'(offs8);
    tq9   <= tq8;

    temperature_centi <= tq9;
    pressure_centi    <= pq_next;
  end

  assign done = v10;

endmodule

/* verif/baro_temp_pressure_compensation_top_tb.sv */
// Self-checking testbench for the barometric temperature and pressure compensation top.
module baro_temp_pressure_compensation_top_tb;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [D_W-1:0] RAW_MAX = '1;
  localparam longint DIV_TEMP = 64'sd8388608;
  localparam longint DIV_DT_SQ = 64'sd2147483648;
  localparam longint DIV_PRES = 64'sd2097152;
  localparam int TEMP_MARKS [11] = '{2000, 1999, 2001, -1500, -1501, -1499, -4000, -6000,
                                     8500, 9000, 250};

  typedef struct {
    logic signed [TOUT_W-1:0] temperature_centi;
    logic [POUT_W-1:0]        pressure_centi;
  } reading_t;

  class compensation_checker;
    logic [CAL_W-1:0] cal [6];
    reading_t readings_due [$];
    int mismatches;

    function new();
      foreach (cal[i]) cal[i] = '0;
      mismatches = 0;
    endfunction

    function void load_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] data);
      if (idx <= IDX_C6) cal[idx] = data;
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_sample(logic [D_W-1:0] d1_in, logic [D_W-1:0] d2_in);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, t, offs, sens, sq, offs2, sens2, cold, pres;
      reading_t r;
      d1 = longint'(d1_in);
      d2 = longint'(d2_in);
      c1 = longint'(cal[IDX_C1]);
      c2 = longint'(cal[IDX_C2]);
      c3 = longint'(cal[IDX_C3]);
      c4 = longint'(cal[IDX_C4]);
      c5 = longint'(cal[IDX_C5]);
      c6 = longint'(cal[IDX_C6]);
      dt = d2 - c5 * 256;
      t = TEMP_REF + (dt * c6) / DIV_TEMP;
      offs = c2 * 65536 + (dt * c4) / 128;
      sens = c1 * 32768 + (dt * c3) / 256;
      if (t < TEMP_REF) begin
        sq = (t - TEMP_REF) * (t - TEMP_REF);
        offs2 = (sq * 5) / 2;
        sens2 = (sq * 5) / 4;
        if (t < TEMP_COLD) begin
          cold = (t - TEMP_COLD) * (t - TEMP_COLD);
          offs2 += cold * 7;
          sens2 += (cold * 11) / 2;
        end
        t -= (dt * dt) / DIV_DT_SQ;
        offs -= offs2;
        sens -= sens2;
      end
      pres = ((sens * d1) / DIV_PRES - offs) / 32768;
      if (t < TEMP_MIN) t = TEMP_MIN;
      else if (t > TEMP_MAX) t = TEMP_MAX;
      if (pres < PRES_MIN) pres = PRES_MIN;
      else if (pres > PRES_MAX) pres = PRES_MAX;
      r.temperature_centi = t[TOUT_W-1:0];
      r.pressure_centi = pres[POUT_W-1:0];
      readings_due.push_back(r);
    endfunction

    function void check_reading(logic signed [TOUT_W-1:0] t, logic [POUT_W-1:0] p);
      reading_t want;
      if (readings_due.size() == 0) begin
        flag($sformatf("unexpected result: temperature_centi %0d, pressure_centi %0d", t, p));
        return;
      end
      want = readings_due.pop_front();
      if (t !== want.temperature_centi)
        flag($sformatf("temperature_centi: expected %0d, got %0d", want.temperature_centi, t));
      if (p !== want.pressure_centi)
        flag($sformatf("pressure_centi: expected %0d, got %0d", want.pressure_centi, p));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [D_W-1:0] raw_pressure;
  logic [D_W-1:0] raw_temperature;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CAL_W-1:0] cfg_data;
  logic done;
  logic signed [TOUT_W-1:0] temperature_centi;
  logic [POUT_W-1:0] pressure_centi;

  compensation_checker chk;
  logic [CAL_W-1:0] cal_words [6];
  bit steady;
  int unsigned cycle_count = 0;

  baro_temp_pressure_compensation_top DUT (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .raw_pressure      (raw_pressure),
    .raw_temperature   (raw_temperature),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) chk.check_reading(temperature_centi, pressure_centi);
      if (cfg_valid && cfg_ready) chk.load_cal(cfg_index, cfg_data);
      if (start && !busy) chk.note_sample(raw_pressure, raw_temperature);
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // raw temperature word that lands near a target temperature under the current calibration
  function automatic logic [D_W-1:0] raw_temp_for(int target);
    longint dt, d2;
    if (chk.cal[IDX_C6] == 0) dt = 0;
    else dt = (longint'(target - TEMP_REF) * DIV_TEMP) / longint'(chk.cal[IDX_C6]);
    d2 = longint'(chk.cal[IDX_C5]) * 256 + dt;
    if (d2 < 0) d2 = 0;
    else if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
    return d2[D_W-1:0];
  endfunction

  task automatic send_sample(logic [D_W-1:0] d1, logic [D_W-1:0] d2);
    int gap;
    start <= 1'b1;
    raw_pressure <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      raw_pressure <= D_W'($urandom_range(0, RAW_MAX));
      raw_temperature <= D_W'($urandom_range(0, RAW_MAX));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_cal(logic [IDX_W-1:0] idx, logic [CAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if ($urandom_range(0, 3) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_calibration(logic [CAL_W-1:0] words [6], bit with_spares);
    if (with_spares) write_cal(IDX_SPARE_LO, CAL_W'($urandom_range(0, 65535)));
    for (int i = 0; i < 6; i++) begin
      write_cal(IDX_W'(i), words[i]);
      if (with_spares && i == 2) write_cal(IDX_SPARE_HI, CAL_W'($urandom_range(0, 65535)));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) != 0)
        send_sample(D_W'($urandom_range(0, RAW_MAX)),
                    raw_temp_for(int'($urandom_range(0, 14500)) - 5000));
      else
        send_sample(D_W'($urandom_range(0, RAW_MAX)), D_W'($urandom_range(0, RAW_MAX)));
    end
  endtask

  initial begin
    chk = new();
    rst = 1'b1;
    start = 1'b0;
    raw_pressure = '0;
    raw_temperature = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(D_W'($urandom_range(0, RAW_MAX)), D_W'($urandom_range(0, RAW_MAX)));
    send_sample(D_W'($urandom_range(0, RAW_MAX)), D_W'($urandom_range(0, RAW_MAX)));
    drain();

    cal_words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd32768};
    load_calibration(cal_words, 1'b0);
    foreach (TEMP_MARKS[i])
      send_sample(D_W'($urandom_range(0, RAW_MAX)), raw_temp_for(TEMP_MARKS[i]));
    send_sample('0, raw_temp_for(TEMP_REF));
    send_sample(RAW_MAX, raw_temp_for(TEMP_REF));
    send_sample(RAW_MAX, '0);
    send_sample('0, RAW_MAX);
    send_sample(24'd9085466, 24'd8569150);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cal_words = '{6{16'hFFFF}};
        1: cal_words = '{6{16'h0000}};
        2: cal_words = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
        3: cal_words = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
        7: foreach (cal_words[i]) cal_words[i] = CAL_W'($urandom_range(0, 65535));
        default: cal_words = '{CAL_W'($urandom_range(15000, 65535)),
                               CAL_W'($urandom_range(15000, 65535)),
                               CAL_W'($urandom_range(15000, 65535)),
                               CAL_W'($urandom_range(15000, 65535)),
                               CAL_W'($urandom_range(20000, 40000)),
                               CAL_W'($urandom_range(15000, 40000))};
      endcase
      load_calibration(cal_words, p == 2 || p == 5);
      steady = (p % 3 == 1);
      run_phase(110);
      drain();
    end

    repeat (15) @(posedge clk);
    if (chk.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
